### rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Huffman code bit packer.
// No dependencies; every other file uses this package by scoped names.
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 24;
    localparam int SYMBOL_COUNT = 256;
    localparam int BYTE_BITS = 8;
    localparam int CODE_FIELD_BITS = 24;
    localparam int LEN_W = 5;
    localparam int SYM_W = 8;
    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_FIELD_BITS) ? MAX_CODE_LEN
                                                                 : CODE_FIELD_BITS;
    localparam int ACC_W = BYTE_BITS - 1;
    localparam int CNT_W = 3;
    localparam int MERGE_W = ACC_W + CODE_FIELD_BITS;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic [SYM_W-1:0]           symbol;
        logic [CODE_FIELD_BITS-1:0] code_bits;
        logic [LEN_W-1:0]           code_length;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 byte_valid;
        logic [2:0]           pad_bits;
        logic                 last;
    } out_beat_t;

    typedef struct packed {
        logic                       hit;
        logic [CODE_FIELD_BITS-1:0] code;
        logic [LEN_W-1:0]           len;
    } lookup_t;

    typedef struct packed {
        logic                       load;
        logic [CODE_FIELD_BITS-1:0] bytes;
        logic [1:0]                 count;
        logic                       byte_valid;
        logic [2:0]                 pad_bits;
    } emit_t;

endpackage

### rtl/hcbp_table.sv
`timescale 1ns / 1ps
// Code table: a 256-entry synchronous memory of code bits and lengths,
// with per-entry valid flags in flip-flops. Depends on hcbp_pkg.
module hcbp_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic                                rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0]          symbol,
    input  logic [hcbp_pkg::CODE_FIELD_BITS-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]          code_length,
    output hcbp_pkg::lookup_t                   lookup
);

    localparam int ENTRY_W = hcbp_pkg::CODE_FIELD_BITS + hcbp_pkg::LEN_W;

    logic [ENTRY_W-1:0] mem [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic hit_reg;

    logic in_range;
    logic [hcbp_pkg::ADDR_W-1:0] addr;
    logic [hcbp_pkg::LEN_W-1:0] len_sat;
    logic [hcbp_pkg::CODE_FIELD_BITS:0] mask_wide;
    logic [hcbp_pkg::CODE_FIELD_BITS-1:0] code_masked;

    assign in_range = ({1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
    assign addr = symbol[hcbp_pkg::ADDR_W-1:0];
    assign len_sat = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LIMIT))
                   ? hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LIMIT) : code_length;
    assign mask_wide = ((hcbp_pkg::CODE_FIELD_BITS + 1)'(1) << len_sat)
                     - (hcbp_pkg::CODE_FIELD_BITS + 1)'(1);
    assign code_masked = code_bits & mask_wide[hcbp_pkg::CODE_FIELD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en && in_range) begin
            mem[addr] <= {len_sat, code_masked};
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (wr_en && in_range) begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= in_range && valid_reg[addr];
            end
        end
    end

    assign lookup.hit = hit_reg;
    assign lookup.code = rd_data_reg[hcbp_pkg::CODE_FIELD_BITS-1:0];
    assign lookup.len = rd_data_reg[ENTRY_W-1:hcbp_pkg::CODE_FIELD_BITS];

endmodule

### rtl/hcbp_pack.sv
`timescale 1ns / 1ps
// Merge stage: holds the pending bit accumulator, appends looked-up codes
// and hands completed bytes or flush results to the emitter. Depends on hcbp_pkg.
module hcbp_pack (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [1:0]        in_opcode,
    input  hcbp_pkg::lookup_t lookup,
    input  logic              emit_free,
    output logic              stage_busy,
    output logic              stage_advance,
    output hcbp_pkg::emit_t   emit
);

    logic                        s1_valid_reg;
    logic [1:0]                  s1_op_reg;
    logic [hcbp_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [hcbp_pkg::CNT_W-1:0]  pend_reg, pend_next;

    logic [hcbp_pkg::LEN_W-1:0]   total;
    logic [hcbp_pkg::MERGE_W-1:0] merged;
    logic [1:0]                   nbytes;
    logic                         is_encode;
    logic                         is_flush;
    logic                         needs_out;

    assign is_encode = (s1_op_reg == hcbp_pkg::OP_ENCODE) && lookup.hit;
    assign is_flush = (s1_op_reg == hcbp_pkg::OP_FLUSH);
    assign total = hcbp_pkg::LEN_W'(pend_reg) + lookup.len;
    assign nbytes = total[hcbp_pkg::LEN_W-1:3];
    assign merged = hcbp_pkg::MERGE_W'(acc_reg)
                  | (hcbp_pkg::MERGE_W'(lookup.code) << pend_reg);
    assign needs_out = is_flush || (is_encode && (nbytes != 2'd0));

    assign stage_busy = s1_valid_reg;
    assign stage_advance = s1_valid_reg && (!needs_out || emit_free);

    always_comb begin
        acc_next = acc_reg;
        pend_next = pend_reg;
        emit.load = s1_valid_reg && needs_out && emit_free;
        emit.bytes = merged[hcbp_pkg::CODE_FIELD_BITS-1:0];
        emit.count = nbytes;
        emit.byte_valid = 1'b1;
        emit.pad_bits = 3'd0;
        if (is_flush) begin
            acc_next = '0;
            pend_next = '0;
            emit.bytes = hcbp_pkg::CODE_FIELD_BITS'(acc_reg);
            emit.count = 2'd1;
            emit.byte_valid = (pend_reg != '0);
            emit.pad_bits = 3'd0 - pend_reg;
        end else if (is_encode) begin
            pend_next = total[2:0];
            case (nbytes)
                2'd0: acc_next = merged[6:0];
                2'd1: acc_next = merged[14:8];
                2'd2: acc_next = merged[22:16];
                default: acc_next = merged[30:24];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_op_reg <= hcbp_pkg::OP_LOAD;
            acc_reg <= '0;
            pend_reg <= '0;
        end else begin
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
                s1_op_reg <= in_opcode;
            end else if (stage_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (stage_advance) begin
                acc_reg <= acc_next;
                pend_reg <= pend_next;
            end
        end
    end

endmodule

### rtl/hcbp_emit.sv
`timescale 1ns / 1ps
// Output stage: holds up to three result bytes and presents one beat per
// cycle on the result channel while m_ready is high. Depends on hcbp_pkg.
module hcbp_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcbp_pkg::emit_t     emit,
    output logic                emit_free,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbp_pkg::out_beat_t m_data
);

    logic [hcbp_pkg::CODE_FIELD_BITS-1:0] buf_reg;
    logic [1:0] cnt_reg;
    logic bvalid_reg;
    logic [2:0] pad_reg;

    assign m_valid = (cnt_reg != 2'd0);
    assign emit_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    assign m_data.out_byte = buf_reg[hcbp_pkg::BYTE_BITS-1:0];
    assign m_data.byte_valid = bvalid_reg;
    assign m_data.pad_bits = pad_reg;
    assign m_data.last = (cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (emit.load) begin
            cnt_reg <= emit.count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.load) begin
            buf_reg <= emit.bytes;
            bvalid_reg <= emit.byte_valid;
            pad_reg <= emit.pad_bits;
        end else if (m_valid && m_ready) begin
            buf_reg <= buf_reg >> hcbp_pkg::BYTE_BITS;
        end
    end

endmodule

### rtl/huffman_code_bit_packer_unit.sv
`timescale 1ns / 1ps
// Top level of the Huffman code bit packer, LSB first.
// Instantiates hcbp_table, hcbp_pack and hcbp_emit; uses hcbp_pkg.
//
// Usage: the input channel (s_valid, s_ready, s_data) carries load, encode
// and flush beats. A load writes one code table entry and gives no result.
// An encode looks up its symbol and gives one result beat per completed
// byte, up to three, with last on the final one; it gives none if no byte
// completes or the symbol has no entry. A flush always gives one beat with
// the padded pending bits and the pad count. Results leave on m_valid,
// m_ready, m_data.
// Result path: an encode reads the table into its read register as the input
// beat is taken, and the merged bits are then loaded into the output register
// once that register is free.
// Throughput: one input beat per cycle while each item gives at most one
// result beat and m_ready is high; an encode that completes several bytes
// holds the output register until its beats are all taken; a later item with a result waits for it.
// Reset: the table valid flags, the bit accumulator and all stages are
// cleared at once; table contents are undefined until loaded.
// A stalled receiver holds the current beat; the merge stage then fills and
// s_ready drops until the output register frees up.
module huffman_code_bit_packer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hcbp_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbp_pkg::out_beat_t m_data
);

    hcbp_pkg::lookup_t lookup;
    hcbp_pkg::emit_t   emit;
    logic in_accept;
    logic stage_busy;
    logic stage_advance;
    logic emit_free;

    assign s_ready = !stage_busy || stage_advance;
    assign in_accept = s_valid && s_ready;

    hcbp_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (in_accept && (s_data.opcode == hcbp_pkg::OP_LOAD)),
        .rd_en       (in_accept && (s_data.opcode == hcbp_pkg::OP_ENCODE)),
        .symbol      (s_data.symbol),
        .code_bits   (s_data.code_bits),
        .code_length (s_data.code_length),
        .lookup      (lookup)
    );

    hcbp_pack u_pack (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .in_opcode     (s_data.opcode),
        .lookup        (lookup),
        .emit_free     (emit_free),
        .stage_busy    (stage_busy),
        .stage_advance (stage_advance),
        .emit          (emit)
    );

    hcbp_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .emit      (emit),
        .emit_free (emit_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/hcbp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_unit.
module hcbp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hcbp_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input hcbp_pkg::out_beat_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result beat shown right after reset.");

    a_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.byte_valid && (m_data.pad_bits == 3'd0))
        else $error("Non-final beat is not a plain data byte.");

    a_empty_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid
            |-> m_data.last && (m_data.pad_bits == 3'd0) && (m_data.out_byte == 8'd0))
        else $error("Empty flush beat carries data.");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid)
        else $error("Run of result beats ended without last.");

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_data);

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### test/hcbp_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the Huffman code bit packer: it tracks the code table and bit
// accumulator from accepted input beats and compares every result beat in order.
// Depends on hcbp_pkg for the beat types, opcodes and size constants.
module hcbp_stream_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  hcbp_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  hcbp_pkg::out_beat_t m_data,
    output int                  mismatches,
    output int                  beats_checked,
    output int                  backlog
);

    logic [hcbp_pkg::CODE_FIELD_BITS-1:0] code_table [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::LEN_W-1:0]           length_table [hcbp_pkg::SYMBOL_COUNT];
    bit                                   entry_loaded [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::ACC_W-1:0]           held_bits;
    logic [2:0]                           held_count;
    hcbp_pkg::out_beat_t                  packed_bytes [$];

    task automatic pack_item(input hcbp_pkg::in_beat_t beat);
        logic [hcbp_pkg::MERGE_W-1:0] merged;
        logic [hcbp_pkg::CODE_FIELD_BITS:0] mask;
        logic [hcbp_pkg::LEN_W-1:0] len;
        hcbp_pkg::out_beat_t res;
        int total;
        int nbytes;
        case (beat.opcode)
            hcbp_pkg::OP_LOAD: begin
                len = beat.code_length;
                if (len > hcbp_pkg::CODE_LIMIT) begin
                    len = hcbp_pkg::CODE_LIMIT;
                end
                mask = ({{hcbp_pkg::CODE_FIELD_BITS{1'b0}}, 1'b1} << len) - 1'b1;
                code_table[beat.symbol] = beat.code_bits
                                          & mask[hcbp_pkg::CODE_FIELD_BITS-1:0];
                length_table[beat.symbol] = len;
                entry_loaded[beat.symbol] = 1'b1;
            end
            hcbp_pkg::OP_ENCODE: begin
                if (entry_loaded[beat.symbol]) begin
                    merged = '0;
                    merged[hcbp_pkg::CODE_FIELD_BITS-1:0] = code_table[beat.symbol];
                    merged = merged << held_count;
                    merged[hcbp_pkg::ACC_W-1:0] = merged[hcbp_pkg::ACC_W-1:0] | held_bits;
                    total = int'(held_count) + int'(length_table[beat.symbol]);
                    nbytes = total / hcbp_pkg::BYTE_BITS;
                    for (int k = 0; k < nbytes; k++) begin
                        res.out_byte = merged[hcbp_pkg::BYTE_BITS-1:0];
                        res.byte_valid = 1'b1;
                        res.pad_bits = 3'd0;
                        res.last = (k == nbytes - 1);
                        packed_bytes.push_back(res);
                        merged = merged >> hcbp_pkg::BYTE_BITS;
                    end
                    held_count = 3'(total % hcbp_pkg::BYTE_BITS);
                    held_bits = merged[hcbp_pkg::ACC_W-1:0]
                                & ((7'd1 << held_count) - 7'd1);
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                res.last = 1'b1;
                if (held_count == 3'd0) begin
                    res.out_byte = '0;
                    res.byte_valid = 1'b0;
                    res.pad_bits = 3'd0;
                end else begin
                    res.out_byte = {1'b0, held_bits};
                    res.byte_valid = 1'b1;
                    res.pad_bits = 3'(hcbp_pkg::BYTE_BITS - held_count);
                end
                packed_bytes.push_back(res);
                held_bits = '0;
                held_count = '0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        hcbp_pkg::out_beat_t want;
        if (!aresetn) begin
            foreach (entry_loaded[i]) begin
                entry_loaded[i] = 1'b0;
            end
            held_bits = '0;
            held_count = '0;
            packed_bytes.delete();
            mismatches = 0;
            beats_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (packed_bytes.size() == 0) begin
                    $error("out_byte: expected no beat, got %0h", m_data.out_byte);
                    mismatches++;
                end else begin
                    want = packed_bytes.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("byte_valid", want.byte_valid, m_data.byte_valid);
                    check_field("pad_bits", want.pad_bits, m_data.pad_bits);
                    check_field("last", want.last, m_data.last);
                    beats_checked++;
                end
            end
            if (s_valid && s_ready) begin
                pack_item(s_data);
            end
        end
        backlog = packed_bytes.size();
    end

endmodule

### test/huffman_code_bit_packer_unit_tb.sv
`timescale 1ns / 1ps
// Top of the bit packer testbench: clock, reset, directed and random beats, random
// receiver back-pressure and the verdict. Uses hcbp_pkg, hcbp_stream_checker and
// the huffman_code_bit_packer_unit RTL.
module huffman_code_bit_packer_unit_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS = 2_000_000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hcbp_pkg::in_beat_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hcbp_pkg::out_beat_t m_data;

    int mismatches;
    int beats_checked;
    int backlog;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_request = 1'b0;
    int n_load = 0;
    int n_encode = 0;
    int n_flush = 0;
    int n_unused = 0;
    logic [7:0] loaded_syms [$];

    huffman_code_bit_packer_unit i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    hcbp_stream_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .beats_checked(beats_checked),
        .backlog      (backlog)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [7:0] sym,
                             input logic [23:0] bits, input logic [4:0] len);
        int gap;
        hcbp_pkg::in_beat_t beat;
        gap = tx_calm ? 0 : draw_gap();
        beat.opcode = op;
        beat.symbol = sym;
        beat.code_bits = bits;
        beat.code_length = len;
        case (op)
            hcbp_pkg::OP_LOAD: begin
                n_load++;
                loaded_syms.push_back(sym);
            end
            hcbp_pkg::OP_ENCODE: n_encode++;
            hcbp_pkg::OP_FLUSH: n_flush++;
            default: n_unused++;
        endcase
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_item();
        int r;
        logic [7:0] sym;
        logic [4:0] len;
        r = $urandom_range(0, 99);
        if (r < 16) begin
            sym = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15) * 17)
                                             : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 75) begin
                len = 5'($urandom_range(1, 12));
            end else if (r < 88) begin
                len = 5'($urandom_range(13, 24));
            end else if (r < 94) begin
                len = 5'd0;
            end else begin
                len = 5'($urandom_range(25, 31));
            end
            send_beat(hcbp_pkg::OP_LOAD, sym, 24'($urandom()), len);
        end else if (r < 84) begin
            if (loaded_syms.size() > 0 && $urandom_range(0, 9) < 9) begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end else begin
                sym = 8'($urandom_range(0, 255));
            end
            send_beat(hcbp_pkg::OP_ENCODE, sym, 24'($urandom()), 5'($urandom()));
        end else if (r < 96) begin
            send_beat(hcbp_pkg::OP_FLUSH, 8'($urandom()), 24'($urandom()),
                      5'($urandom()));
        end else begin
            send_beat(OP_UNUSED, 8'($urandom()), 24'($urandom()), 5'($urandom()));
        end
    endtask

    initial begin
        int stall_left;
        int g;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                g = rx_calm ? 0 : draw_gap();
                if (g == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    stall_left = g - 1;
                    m_ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("huffman_code_bit_packer_unit: mismatch");
        $finish;
    end

    initial begin
        int sent;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty flush, missing entry, saturated and zero lengths,
        // exact byte fills, three-byte emits, padded flushes and the unused opcode.
        send_beat(hcbp_pkg::OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h00, 24'hFFFFFF, 5'd31);
        send_beat(hcbp_pkg::OP_LOAD, 8'h00, 24'hFFFFFF, 5'd31);
        send_beat(hcbp_pkg::OP_LOAD, 8'hFF, 24'hABCDEF, 5'd0);
        send_beat(hcbp_pkg::OP_LOAD, 8'h55, 24'hFFFFF5, 5'd3);
        send_beat(hcbp_pkg::OP_LOAD, 8'hAA, 24'hFFFFFF, 5'd5);
        send_beat(hcbp_pkg::OP_LOAD, 8'h01, 24'h000000, 5'd24);
        send_beat(hcbp_pkg::OP_ENCODE, 8'hFF, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h55, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h00, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'hAA, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h55, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_beat(OP_UNUSED, 8'hFF, 24'hFFFFFF, 5'd31);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_LOAD, 8'h80, 24'h00007F, 5'd7);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h80, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h00, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h81, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_ENCODE, 8'h80, 24'h000000, 5'd0);
        send_beat(hcbp_pkg::OP_FLUSH, 8'h00, 24'h000000, 5'd0);

        // Random part in three stretches: idling on both sides, then back-to-back
        // beats with one long receiver hold-off, then idling again.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 3) begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
                hold_request = 1'b1;
            end else if (sent == 2 * RANDOM_ITEMS / 3) begin
                tx_calm = 1'b0;
                rx_calm = 1'b0;
            end
            g_count_before: begin
                int unused_before;
                unused_before = n_unused;
                send_random_item();
                if (n_unused == unused_before) begin
                    sent++;
                end
            end
        end
        send_beat(hcbp_pkg::OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        @(negedge aclk);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d loads, %0d encodes, %0d flushes and %0d unused-opcode beats.",
                 n_load, n_encode, n_flush, n_unused);
        $display("Checked %0d result beats, including a %0d-cycle receiver hold-off.",
                 beats_checked, LONG_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("huffman_code_bit_packer_unit: match");
        end else begin
            $display("huffman_code_bit_packer_unit: mismatch");
        end
        $finish;
    end

endmodule

### huffman_code_bit_packer_unit.f
rtl/hcbp_pkg.sv
rtl/hcbp_table.sv
rtl/hcbp_pack.sv
rtl/hcbp_emit.sv
rtl/huffman_code_bit_packer_unit.sv
rtl/hcbp_checker.sv
test/hcbp_stream_checker.sv
test/huffman_code_bit_packer_unit_tb.sv
